// File: src/lfsr_monte_carlo_pi_trial_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LFSR Monte Carlo pi trial unit
// Concurrent checks on clk, inactive while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LFSR_MONTE_CARLO_PI_TRIAL_UNIT_DEFINES_SVH
`define LFSR_MONTE_CARLO_PI_TRIAL_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LMCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LMCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lmcp_pkg.sv
// ----------------------------------------------------------------------------
// lmcp_pkg
// Constants, types and LFSR step functions for the Monte Carlo pi trial unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lmcp_pkg;

  localparam int OUT_W   = 20;
  localparam int LIMIT_W = 20;
  localparam int ADDR_W  = 4;

  localparam logic [31:0] MASK_LONG        = 32'hB4BC_D35C;
  localparam logic [30:0] MASK_SHORT       = 31'h7A5B_C2E3;
  localparam logic [31:0] SEED_LONG_RESET  = 32'h000A_BCDE;
  localparam logic [30:0] SEED_SHORT_RESET = 31'h2345_6789;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd250000;
  localparam logic [63:0] UNIT_SQUARED     = 64'h3FFF_FFFF_0000_0001;

  localparam logic [1:0] REG_SEED_LONG   = 2'd0;
  localparam logic [1:0] REG_SEED_SHORT  = 2'd1;
  localparam logic [1:0] REG_TRIAL_LIMIT = 2'd2;

  typedef struct packed {
    logic advance;
    logic restart;
  } lfsr_ctrl_t;

  function automatic logic [31:0] step_long(input logic [31:0] r);
    logic [31:0] sh;
    sh = {1'b0, r[31:1]};
    return r[0] ? (sh ^ MASK_LONG) : sh;
  endfunction

  function automatic logic [30:0] step_short(input logic [30:0] r);
    logic [30:0] sh;
    sh = {1'b0, r[30:1]};
    return r[0] ? (sh ^ MASK_SHORT) : sh;
  endfunction

  // two's complement magnitude; 0x80000000 gives 2^31
  function automatic logic [31:0] magnitude(input logic [31:0] b);
    return b[31] ? (~b + 32'd1) : b;
  endfunction

endpackage

`default_nettype wire

// File: src/lfsr_monte_carlo_pi_trial_unit.sv
// ----------------------------------------------------------------------------
// lfsr_monte_carlo_pi_trial_unit
// One Monte Carlo pi trial per input transfer, with running batch counts.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   in_       in         in_valid / in_stall    in_restart
//   out_      out        out_valid / out_stall  out_hit, out_hits_so_far,
//                                               out_trials_so_far, out_last
//   config    in         APB write/read         seed_long, seed_short, trial_limit
//
// One trial per cycle sustained while out_stall is low; a trial passes the draw
// register, square register, then compare/count into the result register.
// Synchronous active-low reset; no clearing pass, input taken from the first
// cycle after reset.
// out_stall backs up the pipe; empty stages still fill, so in_stall rises
// only when all three stages hold a trial.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lfsr_monte_carlo_pi_trial_unit_defines.svh"

module lfsr_monte_carlo_pi_trial_unit #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_restart,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic [lmcp_pkg::OUT_W-1:0]       out_hits_so_far,
  output logic [lmcp_pkg::OUT_W-1:0]       out_trials_so_far,
  output logic                             out_last,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lmcp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [31:0] seed_long_r;
  logic [30:0] seed_short_r;
  logic [lmcp_pkg::LIMIT_W-1:0] trial_limit_r;
  logic [1:0]  cfg_idx;
  logic        cfg_wr;

  logic out_ready, s2_ready, s1_ready, in_take, s1_move, s2_move;

  lmcp_pkg::lfsr_ctrl_t lfsr_ctrl;
  logic [31:0] x_mag, y_mag;

  logic        s1_v_r, s1_restart_r;
  logic [31:0] s1_xmag_r, s1_ymag_r;
  logic        s2_v_r, s2_restart_r;
  logic [63:0] s2_xsq_r, s2_ysq_r;

  logic [64:0] sum;
  logic        hit_nxt, last_nxt;
  logic [COUNT_BITS-1:0] trial_total_r, hit_total_r;
  logic [COUNT_BITS-1:0] trial_base, hit_base, trial_nxt, hit_cnt_nxt;

  logic        out_valid_r, out_hit_r, out_last_r;
  logic [lmcp_pkg::OUT_W-1:0] out_hits_r, out_trials_r;

  // configuration
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      lmcp_pkg::REG_SEED_LONG:   prdata = seed_long_r;
      lmcp_pkg::REG_SEED_SHORT:  prdata = {1'b0, seed_short_r};
      lmcp_pkg::REG_TRIAL_LIMIT: prdata = 32'(trial_limit_r);
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_long_r   <= lmcp_pkg::SEED_LONG_RESET;
      seed_short_r  <= lmcp_pkg::SEED_SHORT_RESET;
      trial_limit_r <= lmcp_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lmcp_pkg::REG_SEED_LONG:   seed_long_r   <= pwdata;
        lmcp_pkg::REG_SEED_SHORT:  seed_short_r  <= pwdata[30:0];
        lmcp_pkg::REG_TRIAL_LIMIT: trial_limit_r <= pwdata[lmcp_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe flow control
  always_comb begin
    out_ready = !out_valid_r || !out_stall;
    s2_ready  = !s2_v_r || out_ready;
    s1_ready  = !s1_v_r || s2_ready;
    in_take   = in_valid && s1_ready;
    s1_move   = s1_v_r && s2_ready;
    s2_move   = s2_v_r && out_ready;
  end
  assign in_stall = !s1_ready;

  assign lfsr_ctrl.advance = in_take;
  assign lfsr_ctrl.restart = in_restart;

  lmcp_lfsr_pair u_lfsr (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (lfsr_ctrl),
    .seed_long  (seed_long_r),
    .seed_short (seed_short_r),
    .x_mag      (x_mag),
    .y_mag      (y_mag)
  );

  // draw stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_restart_r <= in_restart;
      s1_xmag_r    <= x_mag;
      s1_ymag_r    <= y_mag;
    end
  end

  // square stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_restart_r <= s1_restart_r;
      s2_xsq_r     <= 64'(s1_xmag_r) * 64'(s1_xmag_r);
      s2_ysq_r     <= 64'(s1_ymag_r) * 64'(s1_ymag_r);
    end
  end

  // compare and count
  always_comb begin
    sum         = {1'b0, s2_xsq_r} + {1'b0, s2_ysq_r};
    hit_nxt     = sum < {1'b0, lmcp_pkg::UNIT_SQUARED};
    trial_base  = s2_restart_r ? '0 : trial_total_r;
    hit_base    = s2_restart_r ? '0 : hit_total_r;
    trial_nxt   = trial_base + COUNT_BITS'(1);
    hit_cnt_nxt = hit_nxt ? (hit_base + COUNT_BITS'(1)) : hit_base;
    last_nxt    = trial_nxt == COUNT_BITS'(trial_limit_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trial_total_r <= '0;
      hit_total_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= s2_v_r;
      end
      if (s2_move) begin
        trial_total_r <= last_nxt ? '0 : trial_nxt;
        hit_total_r   <= last_nxt ? '0 : hit_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_hit_r    <= hit_nxt;
      out_hits_r   <= lmcp_pkg::OUT_W'(hit_cnt_nxt);
      out_trials_r <= lmcp_pkg::OUT_W'(trial_nxt);
      out_last_r   <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_hits_so_far   = out_hits_r;
  assign out_trials_so_far = out_trials_r;
  assign out_last          = out_last_r;

  `LMCP_ASSERT_NOW(a_hits_le_trials, 1'b1, hit_total_r <= trial_total_r,
                   "hit count above trial count")
  `LMCP_ASSERT_NEXT(a_last_clears, s2_move && last_nxt,
                    trial_total_r == '0 && hit_total_r == '0,
                    "counts not cleared after batch end")
  `LMCP_ASSERT_NOW(a_stall_full, in_stall, s1_v_r && s2_v_r && out_valid_r,
                   "input stalled with a free stage")
  `LMCP_ASSERT_NEXT(a_s2_to_out, s2_move, out_valid_r,
                    "trial lost between square and result stage")

endmodule

`default_nettype wire

// File: src/lmcp_lfsr_pair.sv
// ----------------------------------------------------------------------------
// lmcp_lfsr_pair
// Long and short Galois LFSRs; draws the x and y magnitudes of one trial.
// ----------------------------------------------------------------------------
`default_nettype none

module lmcp_lfsr_pair (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lmcp_pkg::lfsr_ctrl_t ctrl,
  input  wire logic [31:0]         seed_long,
  input  wire logic [30:0]         seed_short,
  output logic [31:0]              x_mag,
  output logic [31:0]              y_mag
);

  logic [31:0] long_r, long_nxt;
  logic [30:0] short_r, short_nxt;
  logic [31:0] base_l, l_a;
  logic [30:0] base_s, s_a;

  always_comb begin
    base_l    = ctrl.restart ? seed_long : long_r;
    base_s    = ctrl.restart ? seed_short : short_r;
    l_a       = lmcp_pkg::step_long(lmcp_pkg::step_long(base_l));
    s_a       = lmcp_pkg::step_short(base_s);
    long_nxt  = lmcp_pkg::step_long(lmcp_pkg::step_long(l_a));
    short_nxt = lmcp_pkg::step_short(s_a);
    x_mag     = lmcp_pkg::magnitude(l_a ^ {1'b0, s_a});
    y_mag     = lmcp_pkg::magnitude(long_nxt ^ {1'b0, short_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r  <= lmcp_pkg::SEED_LONG_RESET;
      short_r <= lmcp_pkg::SEED_SHORT_RESET;
    end else if (ctrl.advance) begin
      long_r  <= long_nxt;
      short_r <= short_nxt;
    end
  end

endmodule

`default_nettype wire
